// File: src/dss_pkg.sv
// dss_pkg: types, constants and helper functions of the dac shadow scrubber
// used by every module of the block but dss_ram; depends on nothing
`default_nettype none

package dss_pkg;

  localparam int CARDS_DEF      = 32;
  localparam int WORDS_PER_CARD = 32;
  localparam int CARD_W         = 5;
  localparam int IDX_W          = 5;
  localparam int REG_ADDR_W     = 7;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic [IDX_W-1:0] LAST_WORD_IDX = 5'd31;

  localparam logic [7:0] LOW_BASE  = 8'h67;
  localparam logic [7:0] MID_BASE  = 8'h60;
  localparam logic [7:0] HIGH_BASE = 8'h97;
  localparam logic [IDX_W-1:0] MID_START  = 5'd8;
  localparam logic [IDX_W-1:0] HIGH_START = 5'd24;

  typedef struct packed {
    logic                cmd;
    logic [CARD_W-1:0]   card;
    logic [IDX_W-1:0]    word_index;
    logic [VALUE_W-1:0]  word_value;
    logic [STATUS_W-1:0] status_first;
    logic [STATUS_W-1:0] status_second;
  } item_t;

  typedef struct packed {
    logic [CARD_W-1:0]     out_card;
    logic [REG_ADDR_W-1:0] out_address;
    logic [VALUE_W-1:0]    out_value;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic                  valid;
    logic                  from_mem;
    logic [CARD_W-1:0]     card;
    logic [REG_ADDR_W-1:0] address;
    logic [VALUE_W-1:0]    value;
    logic                  last;
  } stage_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  function automatic logic [REG_ADDR_W-1:0] word_address(input logic [IDX_W-1:0] idx);
    logic [7:0] a;
    if (idx < MID_START) begin
      a = LOW_BASE - {3'b000, idx};
    end else if (idx < HIGH_START) begin
      a = MID_BASE + {3'b000, idx};
    end else begin
      a = HIGH_BASE - {3'b000, idx};
    end
    return a[REG_ADDR_W-1:0];
  endfunction

  function automatic logic [WORDS_PER_CARD-1:0] error_mask(
    input logic [STATUS_W-1:0] first,
    input logic [STATUS_W-1:0] second
  );
    logic [WORDS_PER_CARD-1:0] m;
    m = '0;
    for (int j = 0; j < 8; j++) begin
      m[23-j] = first[j];
      m[j]    = first[j+8];
      m[j+8]  = second[j];
      m[31-j] = second[j+8];
    end
    return m;
  endfunction

  function automatic logic [IDX_W-1:0] lowest_bit(input logic [WORDS_PER_CARD-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int j = WORDS_PER_CARD - 1; j >= 0; j--) begin
      if (m[j]) begin
        r = IDX_W'(j);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/dss_ram.sv
// dss_ram: generic single-write, single-read memory with registered read
// no package dependency
`default_nettype none

module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/dss_ctrl.sv
// dss_ctrl: transaction intake, card presence flags, error-mask scan and
// shadow memory access sequencing; depends on dss_pkg
`default_nettype none

module dss_ctrl #(
  parameter int CARDS  = dss_pkg::CARDS_DEF,
  parameter int ADDR_W = $clog2(CARDS * dss_pkg::WORDS_PER_CARD)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire dss_pkg::item_t       in_i,
  output logic                      we_o,
  output logic [ADDR_W-1:0]         waddr_o,
  output logic [dss_pkg::VALUE_W-1:0] wdata_o,
  output logic                      re_o,
  output logic [ADDR_W-1:0]         raddr_o,
  output dss_pkg::stage_t           stage_o
);

  import dss_pkg::*;

  localparam int CIDX_W = (CARDS > 1) ? $clog2(CARDS) : 1;

  state_e                    state_q, state_d;
  logic [CARDS-1:0]          present_q, present_d;
  logic [WORDS_PER_CARD-1:0] mask_q, mask_d, in_mask, rest;
  logic [CARD_W-1:0]         card_q, card_d;
  stage_t                    stage_q, stage_d;
  logic                      accept, card_ok;
  logic [CIDX_W-1:0]         cidx;
  logic [IDX_W-1:0]          pick;

  assign accept  = start && (state_q == ST_IDLE);
  assign card_ok = {1'b0, in_i.card} < (CARD_W + 1)'(CARDS);
  assign cidx    = in_i.card[CIDX_W-1:0];
  assign in_mask = error_mask(in_i.status_first, in_i.status_second);
  assign pick    = lowest_bit(mask_q);
  assign rest    = mask_q & ~(WORDS_PER_CARD'(1) << pick);

  always_comb begin
    state_d   = state_q;
    present_d = present_q;
    mask_d    = mask_q;
    card_d    = card_q;
    stage_d   = '0;
    we_o      = 1'b0;
    re_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && card_ok) begin
          if (in_i.cmd == CMD_LOAD) begin
            we_o             = 1'b1;
            stage_d.valid    = 1'b1;
            stage_d.from_mem = 1'b0;
            stage_d.card     = in_i.card;
            stage_d.address  = word_address(in_i.word_index);
            stage_d.value    = in_i.word_value;
            stage_d.last     = 1'b1;
            if (in_i.word_index == LAST_WORD_IDX) begin
              present_d[cidx] = 1'b1;
            end
          end else if (present_q[cidx] && (in_mask != '0)) begin
            mask_d  = in_mask;
            card_d  = in_i.card;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        re_o             = 1'b1;
        mask_d           = rest;
        stage_d.valid    = 1'b1;
        stage_d.from_mem = 1'b1;
        stage_d.card     = card_q;
        stage_d.address  = word_address(pick);
        stage_d.last     = (rest == '0);
        if (rest == '0) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      present_q <= '0;
      stage_q   <= '0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      stage_q   <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    card_q <= card_d;
  end

  assign busy    = (state_q != ST_IDLE);
  assign waddr_o = ADDR_W'({in_i.card, in_i.word_index});
  assign wdata_o = in_i.word_value;
  assign raddr_o = ADDR_W'({card_q, pick});
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// File: src/dac_shadow_scrubber_unit.sv
// dac_shadow_scrubber_unit: top level, shadow memory, control and result register
// depends on dss_pkg, dss_ram, dss_ctrl
//
//   channel   direction  handshake                 payload
//   item      in         start high, busy low      in_i  (dss_pkg::item_t)
//   result    out        res_strobe_o, one cycle   res_o (dss_pkg::result_t)
//
// a load is accepted without raising busy; its write passes stage_q and then the
// result register, and busy stays low, so loads may follow each other every cycle
// a check with flagged words holds busy through ST_SCAN and ST_DRAIN and emits one
// rewrite a cycle, set by the single read port of the shadow memory
// after reset all cards are absent and shadow words are undefined until loaded
// results cannot be stalled by the receiver
`default_nettype none

module dac_shadow_scrubber_unit #(
  parameter int CARDS = dss_pkg::CARDS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire dss_pkg::item_t   in_i,
  output logic                  res_strobe_o,
  output dss_pkg::result_t      res_o
);

  import dss_pkg::*;

  localparam int DEPTH  = CARDS * WORDS_PER_CARD;
  localparam int ADDR_W = $clog2(DEPTH);

  logic               we, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [VALUE_W-1:0] wdata, rdata;
  stage_t             stage;
  logic               res_valid_q;
  result_t            res_q;

  dss_ctrl #(
    .CARDS  (CARDS),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .re_o    (re),
    .raddr_o (raddr),
    .stage_o (stage)
  );

  dss_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_shadow (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= stage.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage.valid) begin
      res_q.out_card    <= stage.card;
      res_q.out_address <= stage.address;
      res_q.out_value   <= stage.from_mem ? rdata : stage.value;
      res_q.last        <= stage.last;
    end
  end

  assign res_strobe_o = res_valid_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

// File: src/dss_checker.sv
// dss_checker: port-level assertions for dac_shadow_scrubber_unit and its bind
// depends on dss_pkg and the top level's port list
`default_nettype none

module dss_checker #(
  parameter int CARDS = dss_pkg::CARDS_DEF
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire dss_pkg::item_t   in_i,
  input wire logic             res_strobe_o,
  input wire dss_pkg::result_t res_o
);

  import dss_pkg::*;

  logic acc, in_range;

  assign acc      = start && !busy;
  assign in_range = {1'b0, in_i.card} < (CARD_W + 1)'(CARDS);

  // a load transaction on a valid card produces a result with its word and last set
  a_load_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_range && (in_i.cmd == CMD_LOAD) |-> ##2
      (res_strobe_o && res_o.last && (res_o.out_value == $past(in_i.word_value, 2))))
    else $error("load transaction did not produce its write");

  // a rewrite burst is contiguous until last
  a_burst_contig : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.last |=> res_strobe_o)
    else $error("gap inside rewrite burst");

  // every write goes to the 0x60..0x7f window
  a_addr_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.out_address[6:5] == 2'b11))
    else $error("register address outside window");

  // out of range card produces nothing
  a_bad_card : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !in_range |=> !busy ##1 !res_strobe_o)
    else $error("transaction on absent card slot was not ignored");

  // busy only rises after a check transaction
  a_busy_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start) && ($past(in_i.cmd) == CMD_CHECK))
    else $error("busy rose without a check transaction");

endmodule

bind dac_shadow_scrubber_unit dss_checker #(.CARDS(CARDS)) u_dss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .in_i         (in_i),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);

`default_nettype wire

// File: verif/testbench.sv
// testbench: self-checking bench for dac_shadow_scrubber_unit, with its own
// shadow-memory predictor and a write checker; depends on dss_pkg and the rtl
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dss_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int TRAFFIC_ITEMS = 120;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  item_t   in_i   = '0;
  logic    busy;
  logic    res_strobe_o;
  result_t res_o;

  dac_shadow_scrubber_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_i         (in_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [VALUE_W-1:0]        shadow_copy [CARDS_DEF*WORDS_PER_CARD];
  logic [WORDS_PER_CARD-1:0] loaded_words [CARDS_DEF];
  logic                      card_online [CARDS_DEF];
  result_t                   pending_writes [$];

  int sender_idle_pct = 0;
  int mismatches = 0;
  int load_count = 0;
  int check_count = 0;
  int write_count = 0;
  int quiet_cycles = 0;

  function automatic logic [REG_ADDR_W-1:0] reg_address(input logic [IDX_W-1:0] idx);
    int i;
    i = int'(idx);
    if (i <= 7) return REG_ADDR_W'('h67 - i);
    if (i <= 23) return REG_ADDR_W'('h60 + i);
    return REG_ADDR_W'('h97 - i);
  endfunction

  // status registers to flagged words
  function automatic logic [31:0] flag_mask(input logic [15:0] first, input logic [15:0] second);
    logic [31:0] m;
    m[7:0]  = first[15:8];
    m[15:8] = second[7:0];
    for (int i = 0; i < 8; i++) begin
      m[16+i] = first[7-i];
      m[24+i] = second[15-i];
    end
    return m;
  endfunction

  // flagged words back to {first, second}
  function automatic logic [31:0] status_for_mask(input logic [31:0] m);
    logic [15:0] first;
    logic [15:0] second;
    first[15:8] = m[7:0];
    second[7:0] = m[15:8];
    for (int i = 0; i < 8; i++) begin
      first[7-i]   = m[16+i];
      second[15-i] = m[24+i];
    end
    return {first, second};
  endfunction

  function automatic item_t make_load(input int card, input int idx, input logic [31:0] value);
    item_t it;
    it               = '0;
    it.cmd           = CMD_LOAD;
    it.card          = CARD_W'(card);
    it.word_index    = IDX_W'(idx);
    it.word_value    = value;
    it.status_first  = 16'($urandom);
    it.status_second = 16'($urandom);
    return it;
  endfunction

  function automatic item_t make_check(input int card, input logic [31:0] m);
    item_t it;
    it            = '0;
    it.cmd        = CMD_CHECK;
    it.card       = CARD_W'(card);
    it.word_index = IDX_W'($urandom);
    it.word_value = $urandom;
    {it.status_first, it.status_second} = status_for_mask(m);
    return it;
  endfunction

  task automatic predict_writes(input item_t it);
    int          base;
    int          top;
    logic [31:0] flags;
    result_t     w;
    base = int'(it.card) * WORDS_PER_CARD;
    if (it.cmd == CMD_LOAD) begin
      load_count++;
      shadow_copy[base + int'(it.word_index)] = it.word_value;
      loaded_words[it.card][it.word_index] = 1'b1;
      if (it.word_index == LAST_WORD_IDX) card_online[it.card] = 1'b1;
      w.out_card    = it.card;
      w.out_address = reg_address(it.word_index);
      w.out_value   = it.word_value;
      w.last        = 1'b1;
      pending_writes = {pending_writes, w};
    end else begin
      check_count++;
      if (card_online[it.card]) begin
        flags = flag_mask(it.status_first, it.status_second);
        top = -1;
        for (int k = 0; k < WORDS_PER_CARD; k++) begin
          if (flags[k]) top = k;
        end
        for (int k = 0; k < WORDS_PER_CARD; k++) begin
          if (flags[k]) begin
            w.out_card    = it.card;
            w.out_address = reg_address(IDX_W'(k));
            w.out_value   = shadow_copy[base + k];
            w.last        = (k == top);
            pending_writes = {pending_writes, w};
          end
        end
      end
    end
  endtask

  task automatic send_item(input item_t it);
    in_i  <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_writes(it);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      in_i  <= item_t'({$urandom, $urandom, $urandom});
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic drain_writes();
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(make_check(0, '1));
    send_item(make_load(0, 0, 32'h0000_0000));
    send_item(make_load(0, 7, 32'hFFFF_FFFF));
    send_item(make_load(0, 8, 32'h0000_0001));
    send_item(make_load(0, 23, 32'h8000_0000));
    send_item(make_load(0, 24, 32'h5A5A_5A5A));
    send_item(make_check(0, loaded_words[0]));
    send_item(make_load(0, 31, 32'hA5A5_A5A5));
    send_item(make_check(0, loaded_words[0]));
    send_item(make_check(0, 32'h0));
    send_item(make_check(0, 32'h8000_0000));
    send_item(make_check(0, 32'h0000_0001));
    send_item(make_load(31, 31, 32'hFFFF_0000));
    send_item(make_check(31, 32'h8000_0000));
    send_item(make_load(31, 31, 32'h0000_FFFF));
    send_item(make_check(31, 32'h8000_0000));
    send_item(make_load(0, 7, 32'h1234_5678));
    send_item(make_check(0, 32'h0000_0080));
    send_item(make_check(0, loaded_words[0]));
    drain_writes();
  endtask

  // full cards loaded in shuffled word order
  task automatic test_fill_cards();
    int cards [4];
    int order [WORDS_PER_CARD];
    int j;
    int t;
    cards = '{0, 31, $urandom_range(1, 15), $urandom_range(16, 30)};
    foreach (cards[c]) begin
      for (int i = 0; i < WORDS_PER_CARD; i++) order[i] = i;
      for (int i = WORDS_PER_CARD - 1; i > 0; i--) begin
        j = $urandom_range(i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (int i = 0; i < WORDS_PER_CARD; i++) send_item(make_load(cards[c], order[i], $urandom));
    end
    drain_writes();
  endtask

  function automatic item_t make_random_item();
    int          online_list [$];
    int          card;
    int          pick;
    logic [31:0] pattern;
    for (int c = 0; c < CARDS_DEF; c++) begin
      if (card_online[c]) online_list = {online_list, c};
    end
    if (online_list.size() != 0 && $urandom_range(99) < 75) begin
      card = online_list[$urandom_range(online_list.size() - 1)];
    end else begin
      card = $urandom_range(CARDS_DEF - 1);
    end
    if ($urandom_range(99) < 35) begin
      return make_load(card, ($urandom_range(9) == 0) ? 31 : $urandom_range(31), $urandom);
    end
    if (!card_online[card]) return make_check(card, $urandom);
    pick = $urandom_range(99);
    if (pick < 10) pattern = '1;
    else if (pick < 20) pattern = '0;
    else if (pick < 35) pattern = 32'h1 << $urandom_range(31);
    else pattern = $urandom;
    return make_check(card, pattern & loaded_words[card]);
  endfunction

  task automatic test_traffic(input int idle_pct);
    sender_idle_pct = idle_pct;
    for (int n = 0; n < TRAFFIC_ITEMS; n++) send_item(make_random_item());
    drain_writes();
  endtask

  // checker and watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if ((start === 1'b1 && busy === 1'b0) || res_strobe_o === 1'b1) quiet_cycles = 0;
      else quiet_cycles++;
      if (res_strobe_o === 1'b1) begin
        write_count++;
        if (pending_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected write: card %0d addr 0x%02h value 0x%08h last %0b",
                     res_o.out_card, res_o.out_address, res_o.out_value, res_o.last);
          end
        end else begin
          want = pending_writes.pop_front();
          if (res_o.out_card !== want.out_card || res_o.out_address !== want.out_address ||
              res_o.out_value !== want.out_value || res_o.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("write mismatch: expected card %0d addr 0x%02h value 0x%08h last %0b",
                       want.out_card, want.out_address, want.out_value, want.last);
              $display("                actual   card %0d addr 0x%02h value 0x%08h last %0b",
                       res_o.out_card, res_o.out_address, res_o.out_value, res_o.last);
            end
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    for (int c = 0; c < CARDS_DEF; c++) begin
      loaded_words[c] = '0;
      card_online[c]  = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_cards();
    test_traffic(0);
    test_traffic(88);
    test_traffic(13);
    $display("covered %0d loads and %0d checks across idle and back-to-back phases",
             load_count, check_count);
    $display("%0d register writes compared, %0d mismatches", write_count, mismatches);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
